// File: hdl/i2cseq_pkg.sv
package i2cseq_pkg;

  // Bus primitive codes
  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_SEND    = 3'd1;
  localparam logic [2:0] OP_RD_ACK  = 3'd2;
  localparam logic [2:0] OP_RD_NACK = 3'd3;
  localparam logic [2:0] OP_STOP    = 3'd4;
  localparam logic [2:0] OP_WAIT    = 3'd5;

  // Burst modes
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Control byte 1010_bbb_r
  localparam logic [7:0] CTRL_BASE = 8'hA0;

  // Register map
  localparam logic REG_WRITE_WAIT = 1'b0;
  localparam logic [7:0] WRITE_WAIT_RESET = 8'd5;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Longest primitive sequence of one item
  localparam int SEQ_MAX = 7;
  localparam int STEP_W  = 3;

  // One classified item, as handed from front to back
  typedef struct packed {
    logic       mode;     // burst mode
    logic       hdr;      // addressing header goes first
    logic [2:0] blk;      // block bits of the control byte
    logic [7:0] addr_lo;  // low address byte
    logic [7:0] data;     // write data
    logic       last;     // final item of the burst
    logic       close;    // write page closes after this byte
  } desc_t;

  function automatic logic [7:0] ctrl_byte(input logic [2:0] blk, input logic rd);
    ctrl_byte = CTRL_BASE | {4'b0000, blk, rd};
  endfunction

endpackage

// File: hdl/i2cseq_req_if.sv
interface i2cseq_req_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [8:0] address;
  logic [7:0] data;
  logic       last;

  modport source(output valid, mode, address, data, last, input ready);
  modport sink(input valid, mode, address, data, last, output ready);
endinterface

// File: hdl/i2cseq_prim_if.sv
interface i2cseq_prim_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] byte_value;
  logic       last_res;

  modport source(output valid, op, byte_value, last_res, input ready);
  modport sink(input valid, op, byte_value, last_res, output ready);
endinterface

// File: hdl/i2c_eeprom_burst_sequencer_top.sv
// Burst sequencer for a two-block I2C EEPROM: each request item (mode, start address,
// data, last) becomes a run of bus primitives (start, send byte, read with or without
// ack, stop, write-cycle wait). The front classifies an item in the cycle it is
// accepted and queues it (four entries); the back drives one primitive per cycle while a
// job is queued and the output channel accepts them. An item causes 1 primitive for a plain read or
// write byte, 2 for a closing read, 3 for a page-closing write, 6 for a one-byte write
// page and up to 7 for a first read. MEM_BYTES and PAGE_BYTES must be powers of two;
// the block does not check it. write_wait_ms sits at byte address 0 and resets to 5.
module i2c_eeprom_burst_sequencer_top #(
  parameter int MEM_BYTES  = 512,
  parameter int PAGE_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  i2cseq_req_if.sink  req,
  i2cseq_prim_if.source prim,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import i2cseq_pkg::*;

  logic [7:0] write_wait_ms;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  desc_t      q_desc;
  desc_t      head_desc;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WRITE_WAIT) ? {24'd0, write_wait_ms} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_wait_ms <= WRITE_WAIT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_WRITE_WAIT)) begin
      write_wait_ms <= pwdata[7:0];
    end
  end

  i2cseq_front #(
    .MEM_BYTES (MEM_BYTES),
    .PAGE_BYTES(PAGE_BYTES)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .q_full(q_full),
    .q_push(q_push),
    .q_desc(q_desc)
  );

  i2cseq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_desc (q_desc),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_desc (head_desc)
  );

  i2cseq_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (q_valid),
    .job          (head_desc),
    .pop          (q_pop),
    .write_wait_ms(write_wait_ms),
    .prim         (prim)
  );

`ifndef SYNTHESIS
  // A no-ack read is always followed by stop within the same item
  assert property (@(posedge clk) disable iff (rst)
    (prim.valid && prim.ready && prim.op == OP_RD_NACK) |-> !prim.last_res)
    else $error("no-ack read closed an item");

  // Wait closes its item and carries the configured time
  assert property (@(posedge clk) disable iff (rst)
    (prim.valid && prim.ready && prim.op == OP_WAIT) |->
      (prim.last_res && prim.byte_value == write_wait_ms))
    else $error("bad write-cycle wait primitive");

  // A start never ends an item
  assert property (@(posedge clk) disable iff (rst)
    (prim.valid && prim.ready && prim.op == OP_START) |-> !prim.last_res)
    else $error("start closed an item");

  // The queue never drains a job that is not there
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("job popped from empty queue");
`endif

endmodule

// File: hdl/i2cseq_front.sv
module i2cseq_front #(
  parameter int MEM_BYTES  = 512,
  parameter int PAGE_BYTES = 16
) (
  input  logic                clk,
  input  logic                rst,
  i2cseq_req_if.sink          req,
  input  logic                q_full,
  output logic                q_push,
  output i2cseq_pkg::desc_t   q_desc
);
  import i2cseq_pkg::*;

  localparam int ADDR_W = $clog2(MEM_BYTES);
  localparam int PG_W   = $clog2(PAGE_BYTES);
  localparam int EXT_W  = (ADDR_W > 9) ? ADDR_W : 9;

  logic              burst_open, burst_open_next;
  logic              burst_mode, burst_mode_next;
  logic              page_open, page_open_next;
  logic [ADDR_W-1:0] next_address, next_address_next;

  logic              first;
  logic              mode_eff;
  logic              page_eff;
  logic [EXT_W-1:0]  addr_ext;
  logic [ADDR_W-1:0] addr_cur;
  logic [ADDR_W-1:0] addr_inc;
  logic [ADDR_W+2:0] addr_hi;
  logic              close;

  assign req.ready = !q_full;
  assign q_push    = req.valid && !q_full;

  // Classify the item against the burst state
  always_comb begin
    first    = !burst_open;
    mode_eff = first ? req.mode : burst_mode;
    page_eff = first ? 1'b0 : page_open;
    addr_ext = EXT_W'(req.address);
    addr_cur = first ? addr_ext[ADDR_W-1:0] : next_address;
    addr_inc = addr_cur + ADDR_W'(1);
    addr_hi  = (ADDR_W+3)'(addr_cur) >> 8;
    close    = (mode_eff == MODE_WRITE) &&
               (req.last || (addr_inc[PG_W-1:0] == '0));

    q_desc.mode    = mode_eff;
    q_desc.hdr     = (mode_eff == MODE_READ) ? first : !page_eff;
    q_desc.blk     = addr_hi[2:0];
    q_desc.addr_lo = addr_cur[7:0];
    q_desc.data    = req.data;
    q_desc.last    = req.last;
    q_desc.close   = close;
  end

  // Burst state after this item
  always_comb begin
    burst_open_next   = burst_open;
    burst_mode_next   = burst_mode;
    page_open_next    = page_open;
    next_address_next = next_address;
    if (q_push) begin
      burst_mode_next   = mode_eff;
      next_address_next = addr_inc;
      if (req.last) begin
        burst_open_next = 1'b0;
        page_open_next  = 1'b0;
      end else begin
        burst_open_next = 1'b1;
        page_open_next  = (mode_eff == MODE_WRITE) ? !close : page_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_open   <= 1'b0;
      burst_mode   <= 1'b0;
      page_open    <= 1'b0;
      next_address <= '0;
    end else begin
      burst_open   <= burst_open_next;
      burst_mode   <= burst_mode_next;
      page_open    <= page_open_next;
      next_address <= next_address_next;
    end
  end

endmodule

// File: hdl/i2cseq_queue.sv
module i2cseq_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  i2cseq_pkg::desc_t push_desc,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output i2cseq_pkg::desc_t head_desc
);
  import i2cseq_pkg::*;

  desc_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_desc  = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/i2cseq_back.sv
module i2cseq_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  i2cseq_pkg::desc_t job,
  output logic              pop,
  input  logic [7:0]        write_wait_ms,
  i2cseq_prim_if.source     prim
);
  import i2cseq_pkg::*;

  logic [2:0]        seq_op  [SEQ_MAX];
  logic [7:0]        seq_val [SEQ_MAX];
  logic [STEP_W-1:0] seq_len;
  logic [STEP_W-1:0] step;
  logic              load;
  logic              final_step;

  logic              out_valid;
  logic [2:0]        out_op;
  logic [7:0]        out_val;
  logic              out_last;

  // Expand the job into its primitive list
  always_comb begin
    logic [STEP_W-1:0] n;
    n = '0;
    for (int i = 0; i < SEQ_MAX; i++) begin
      seq_op[i]  = OP_START;
      seq_val[i] = 8'd0;
    end
    if (job.hdr) begin
      seq_op[n] = OP_START; seq_val[n] = 8'd0;                     n = n + STEP_W'(1);
      seq_op[n] = OP_SEND;  seq_val[n] = ctrl_byte(job.blk, 1'b0); n = n + STEP_W'(1);
      seq_op[n] = OP_SEND;  seq_val[n] = job.addr_lo;              n = n + STEP_W'(1);
      if (job.mode == MODE_READ) begin
        seq_op[n] = OP_START; seq_val[n] = 8'd0;                     n = n + STEP_W'(1);
        seq_op[n] = OP_SEND;  seq_val[n] = ctrl_byte(job.blk, 1'b1); n = n + STEP_W'(1);
      end
    end
    if (job.mode == MODE_READ) begin
      if (job.last) begin
        seq_op[n] = OP_RD_NACK; n = n + STEP_W'(1);
        seq_op[n] = OP_STOP;    n = n + STEP_W'(1);
      end else begin
        seq_op[n] = OP_RD_ACK;  n = n + STEP_W'(1);
      end
    end else begin
      seq_op[n] = OP_SEND; seq_val[n] = job.data; n = n + STEP_W'(1);
      if (job.close) begin
        seq_op[n] = OP_STOP;                               n = n + STEP_W'(1);
        seq_op[n] = OP_WAIT; seq_val[n] = write_wait_ms;   n = n + STEP_W'(1);
      end
    end
    seq_len = n;
  end

  // One primitive per cycle into the output register while it is empty or being taken
  assign load       = job_valid && (!out_valid || prim.ready);
  assign final_step = (step == seq_len - STEP_W'(1));
  assign pop        = load && final_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        step      <= final_step ? '0 : step + STEP_W'(1);
        out_valid <= 1'b1;
      end else if (prim.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_op   <= seq_op[step];
      out_val  <= seq_val[step];
      out_last <= final_step;
    end
  end

  assign prim.valid      = out_valid;
  assign prim.op         = out_op;
  assign prim.byte_value = out_val;
  assign prim.last_res   = out_last;

endmodule
